[rtl/core/bmhq_pkg.sv]
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int PAY_W        = 32;
  localparam int PRI_W        = 32;
  localparam int TOTAL_W      = 7;
  localparam int STATUS_W     = 2;

  // command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // one heap slot: priority in the upper half, payload in the lower half
  typedef struct packed {
    logic signed [PRI_W-1:0] pri;
    logic        [PAY_W-1:0] pay;
  } entry_t;

endpackage

`default_nettype wire

[rtl/core/binary_max_heap_queue.sv]
// Push: done_o follows the sift-up, which reads 0..log2 CAPACITY parents.
// Pop: done_o follows the sift-down, which reads children through the single read port,
// up to two per level; a pop of the last entry, an empty pop or a full push has no sift.
// A new command is taken the cycle after done_o.
// done_o marks the result for one cycle; the receiver cannot stall it.
// Reset (rst_ni low, asynchronous) empties the heap; memory contents stay undefined.
`default_nettype none

module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                cmd_i,
  input  logic        [bmhq_pkg::PAY_W-1:0]   payload_i,
  input  logic signed [bmhq_pkg::PRI_W-1:0]   priority_req_i,
  output logic                                done_o,
  output logic                                top_valid_o,
  output logic        [bmhq_pkg::PAY_W-1:0]   top_payload_o,
  output logic signed [bmhq_pkg::PRI_W-1:0]   top_priority_o,
  output logic        [bmhq_pkg::TOTAL_W-1:0] entry_total_o,
  output logic        [bmhq_pkg::STATUS_W-1:0] status_o
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_LAST,
    S_DN_L,
    S_DN_R,
    S_PUT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    cidx_q, cidx_d;
  logic [CW-1:0]    count_q, count_d;
  entry_t           item_q, item_d;
  entry_t           child_q, child_d;
  entry_t           root_q;
  status_e          status_q, status_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_rdata;

  logic [AW-1:0]    par;
  logic [AW-1:0]    first_par;
  logic [CW-1:0]    last;
  logic [IW-1:0]    left;
  logic [IW-1:0]    right;
  logic [IW-1:0]    cnt_x;
  logic [IW-1:0]    next_left;
  logic             decide;
  entry_t           pick_e;
  logic [AW-1:0]    pick_i;
  logic [CW+TOTAL_W-1:0] cnt_ext;

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // heap index arithmetic
  assign par       = AW'((pos_q - AW'(1)) >> 1);
  assign first_par = AW'((count_q[AW-1:0] - AW'(1)) >> 1);
  assign last      = count_q - CW'(1);
  assign left      = {pos_q, 1'b1};
  assign right     = left + IW'(1);
  assign cnt_x     = IW'(count_q);

  // pick the larger child, left on ties
  always_comb begin
    if (state_q == S_DN_R && (mem_rdata.pri > child_q.pri)) begin
      pick_e = mem_rdata;
      pick_i = right[AW-1:0];
    end else if (state_q == S_DN_R) begin
      pick_e = child_q;
      pick_i = cidx_q;
    end else begin
      pick_e = mem_rdata;
      pick_i = left[AW-1:0];
    end
  end

  assign next_left = {pick_i, 1'b1};

  // sequence the sift through the heap memory
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cidx_d    = cidx_q;
    count_d   = count_q;
    item_d    = item_q;
    child_d   = child_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = item_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    decide    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d = ST_DONE;
          if (cmd_i == CMD_PUSH) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              state_d  = S_DONE;
            end else begin
              count_d    = count_q + CW'(1);
              item_d.pay = payload_i;
              item_d.pri = priority_req_i;
              pos_d      = count_q[AW-1:0];
              if (count_q == '0) begin
                state_d = S_PUT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = first_par;
                state_d   = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              state_d  = S_DONE;
            end else begin
              count_d = last;
              pos_d   = '0;
              if (count_q == CW'(1)) begin
                state_d = S_DONE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = last[AW-1:0];
                state_d   = S_LAST;
              end
            end
          end
        end
      end

      // parent entry is on the read port
      S_UP: begin
        if (item_q.pri > mem_rdata.pri) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          pos_d     = par;
          if (par == '0) begin
            state_d = S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'((par - AW'(1)) >> 1);
          end
        end else begin
          state_d = S_PUT;
        end
      end

      // last entry becomes the moving item at the root
      S_LAST: begin
        item_d = mem_rdata;
        if (cnt_x > IW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(1);
          state_d   = S_DN_L;
        end else begin
          state_d = S_PUT;
        end
      end

      S_DN_L: begin
        if (right < cnt_x) begin
          child_d   = mem_rdata;
          cidx_d    = left[AW-1:0];
          mem_re    = 1'b1;
          mem_raddr = right[AW-1:0];
          state_d   = S_DN_R;
        end else begin
          decide = 1'b1;
        end
      end

      S_DN_R: begin
        decide = 1'b1;
      end

      S_PUT: begin
        mem_we  = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // move the larger child up, or settle the item
    if (decide) begin
      if (pick_e.pri > item_q.pri) begin
        mem_we    = 1'b1;
        mem_wdata = pick_e;
        pos_d     = pick_i;
        if (next_left < cnt_x) begin
          mem_re    = 1'b1;
          mem_raddr = next_left[AW-1:0];
          state_d   = S_DN_L;
        end else begin
          state_d = S_PUT;
        end
      end else begin
        state_d = S_PUT;
      end
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // hold datapath registers; mirror the root slot
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cidx_q  <= cidx_d;
    item_q  <= item_d;
    child_q <= child_d;
    if (mem_we && mem_waddr == '0) begin
      root_q <= mem_wdata;
    end
  end

  assign cnt_ext = {TOTAL_W'(0), count_q};

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign top_valid_o    = (count_q != '0);
  assign top_payload_o  = top_valid_o ? root_q.pay : '0;
  assign top_priority_o = top_valid_o ? root_q.pri : '0;
  assign entry_total_o  = cnt_ext[TOTAL_W-1:0];
  assign status_o       = status_q;

endmodule

`default_nettype wire

[rtl/core/bmhq_ram.sv]
`default_nettype none

module bmhq_ram #(
  parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  bmhq_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output bmhq_pkg::entry_t    rdata_o
);
  import bmhq_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/bmhq_checker.sv]
`default_nettype none

module bmhq_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 done_o,
  input logic                                 top_valid_o,
  input logic        [bmhq_pkg::PAY_W-1:0]    top_payload_o,
  input logic signed [bmhq_pkg::PRI_W-1:0]    top_priority_o,
  input logic        [bmhq_pkg::TOTAL_W-1:0]  entry_total_o,
  input logic        [bmhq_pkg::STATUS_W-1:0] status_o
);
  import bmhq_pkg::*;

  // a transfer occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  // one result per command, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // result shows while the command is still owned
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("result strobe outside a command");

  // an empty heap reports zero top fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !top_valid_o) |-> (top_payload_o == '0 && top_priority_o == '0))
    else $error("empty heap with nonzero top entry");

  // pop on empty leaves the heap empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (!top_valid_o && entry_total_o == '0))
    else $error("empty pop reported entries");

endmodule

bind binary_max_heap_queue bmhq_checker u_checker (.*);

`default_nettype wire
